// File: rtl/core/ecd_pkg.sv
// ----------------------------------------------------------------------------
// ecd_pkg
// Constants and helpers for the millisecond-epoch to calendar date core.
// ----------------------------------------------------------------------------
package ecd_pkg;

  localparam int unsigned LATENCY = 13;

  localparam int unsigned TS_W = 43;

  // ms per day = 2^10 * DAY_DIV; reciprocals are floor(2^S / d)
  localparam logic [16:0] DAY_DIV    = 17'd84375;
  localparam logic [16:0] DAY_RCP    = 17'd101806;  // S = 33
  localparam logic [17:0] SEC_RCP    = 18'd134217;  // /125,  S = 24
  localparam logic [6:0]  SEC_DIV    = 7'd125;
  localparam logic [5:0]  HOUR_RCP   = 6'd36;       // /3600, S = 17
  localparam logic [11:0] HOUR_DIV   = 12'd3600;
  localparam logic [6:0]  MIN_RCP    = 7'd68;       // /60,   S = 12
  localparam logic [5:0]  MIN_DIV    = 6'd60;

  localparam logic [19:0] SHIFT_DAYS = 20'd719468;  // 1970-01-01 from 0000-03-01
  localparam logic [19:0] ERA4_START = 20'd584388;
  localparam logic [19:0] ERA5_START = 20'd730485;
  localparam logic [7:0]  Q4_RCP     = 8'd179;      // /1460, S = 18
  localparam logic [10:0] Q4_DIV     = 11'd1460;
  localparam logic [17:0] ERA_LAST   = 18'd146096;
  localparam logic [9:0]  YEAR_RCP   = 10'd718;     // /365,  S = 18
  localparam logic [8:0]  YEAR_DAYS  = 9'd365;
  localparam logic [3:0]  MP_RCP     = 4'd13;       // /153,  S = 11
  localparam logic [7:0]  MP_DIV     = 8'd153;

  // year offset for the 1600 era: (1600 - 2000) mod 256
  localparam logic [7:0]  ERA4_YEAR  = 8'd112;

  // first day of each month, counted from 1 March
  function automatic logic [8:0] month_offset(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/epoch_ms_to_calendar_date_core.sv
// ----------------------------------------------------------------------------
// epoch_ms_to_calendar_date_core
// Millisecond count since 1970-01-01 UTC to Gregorian date and time of day.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// Reset clears the valid chain only; an item in flight is dropped.
// Depth is set by the constant-reciprocal divides, each an estimate stage
// followed by a correction stage.
// ----------------------------------------------------------------------------
module epoch_ms_to_calendar_date_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [42:0] timestamp_ms,
  output logic        busy,
  output logic        done,
  output logic [7:0]  year_since_2000,
  output logic [3:0]  month_number,
  output logic [4:0]  day_of_month,
  output logic [4:0]  hour_of_day,
  output logic [5:0]  minute_of_hour,
  output logic [5:0]  second_of_minute
);

  logic [ecd_pkg::LATENCY-1:0] vld;

  // stage registers
  logic [33:0] s1_ph;
  logic [32:0] s1_pl;
  logic [32:0] s1_x;
  logic [9:0]  s1_low;

  logic [16:0] s2_q;
  logic [32:0] s2_x;
  logic [9:0]  s2_low;

  logic [16:0] s3_days;
  logic [23:0] s3_x8;

  logic [16:0] s4_se;
  logic [23:0] s4_x8;
  logic [17:0] s4_doe;
  logic        s4_era5;

  logic [16:0] s5_sod;
  logic [6:0]  s5_e1460;
  logic [2:0]  s5_c36;
  logic        s5_last;
  logic [17:0] s5_doe;
  logic        s5_era5;

  logic [4:0]  s6_eh;
  logic [16:0] s6_sod;
  logic [6:0]  s6_q1460;
  logic [2:0]  s6_c36;
  logic        s6_last;
  logic [17:0] s6_doe;
  logic        s6_era5;

  logic [4:0]  s7_hour;
  logic [11:0] s7_mos;
  logic [17:0] s7_num;
  logic [17:0] s7_doe;
  logic        s7_era5;

  logic [5:0]  s8_em;
  logic [11:0] s8_mos;
  logic [4:0]  s8_hour;
  logic [8:0]  s8_ey;
  logic [17:0] s8_num;
  logic [17:0] s8_doe;
  logic        s8_era5;

  logic [4:0]  s9_hour;
  logic [5:0]  s9_min;
  logic [5:0]  s9_sec;
  logic [8:0]  s9_yoe;
  logic [17:0] s9_doe;
  logic        s9_era5;

  logic [4:0]  s10_hour;
  logic [5:0]  s10_min;
  logic [5:0]  s10_sec;
  logic [8:0]  s10_yoe;
  logic [8:0]  s10_doy;
  logic        s10_era5;

  logic [4:0]  s11_hour;
  logic [5:0]  s11_min;
  logic [5:0]  s11_sec;
  logic [8:0]  s11_yoe;
  logic [8:0]  s11_doy;
  logic [3:0]  s11_emp;
  logic        s11_era5;

  logic [4:0]  s12_hour;
  logic [5:0]  s12_min;
  logic [5:0]  s12_sec;
  logic [8:0]  s12_yoe;
  logic [8:0]  s12_doy;
  logic [3:0]  s12_mp;
  logic        s12_era5;

  // combinational
  logic [33:0] ph_c;
  logic [32:0] pl_c;
  logic [49:0] dq_c;
  logic [33:0] dprod_c;
  logic [33:0] drem_c;
  logic        dge_c;
  logic [17:0] rr_c;
  logic [41:0] sp_c;
  logic [19:0] z_c;
  logic        era5_c;
  logic [19:0] doe_c;
  logic [23:0] srem_c;
  logic        sge_c;
  logic [25:0] qp_c;
  logic [22:0] hp_c;
  logic [17:0] qrem_c;
  logic        qge_c;
  logic [16:0] hrem_c;
  logic        hge_c;
  logic [12:0] mos_c;
  logic [18:0] mp_c;
  logic [27:0] yp_c;
  logic [11:0] mrem_c;
  logic        mge_c;
  logic [6:0]  sec_c;
  logic [17:0] yrem_c;
  logic        yge_c;
  logic [1:0]  c100_c;
  logic [17:0] ystart_c;
  logic [17:0] doy_c;
  logic [10:0] v11_c;
  logic [14:0] ep_c;
  logic [10:0] v12_c;
  logic [11:0] mr_c;
  logic        mpge_c;
  logic [8:0]  dom_c;

  assign busy = 1'b0;
  assign done = vld[ecd_pkg::LATENCY-1];

  always_comb begin
    // day count: (ts >> 10) / 84375, split product
    ph_c    = 34'(timestamp_ms[42:26]) * 34'(ecd_pkg::DAY_RCP);
    pl_c    = 33'(timestamp_ms[25:10]) * 33'(ecd_pkg::DAY_RCP);
    dq_c    = {s1_ph, 16'd0} + 50'(s1_pl);
    dprod_c = 34'(s2_q) * 34'(ecd_pkg::DAY_DIV);
    drem_c  = {1'b0, s2_x} - dprod_c;
    dge_c   = drem_c[17:0] >= 18'(ecd_pkg::DAY_DIV);
    rr_c    = dge_c ? (drem_c[17:0] - 18'(ecd_pkg::DAY_DIV)) : drem_c[17:0];

    // seconds of day: (ms of day / 8) / 125
    sp_c    = 42'(s3_x8) * 42'(ecd_pkg::SEC_RCP);
    srem_c  = s4_x8 - 24'(s4_se) * 24'(ecd_pkg::SEC_DIV);
    sge_c   = srem_c[7:0] >= 8'(ecd_pkg::SEC_DIV);

    // era and day of era
    z_c     = 20'(s3_days) + ecd_pkg::SHIFT_DAYS;
    era5_c  = z_c >= ecd_pkg::ERA5_START;
    doe_c   = z_c - (era5_c ? ecd_pkg::ERA5_START : ecd_pkg::ERA4_START);

    qp_c    = 26'(s4_doe) * 26'(ecd_pkg::Q4_RCP);
    qrem_c  = s5_doe - 18'(s5_e1460) * 18'(ecd_pkg::Q4_DIV);
    qge_c   = qrem_c[11:0] >= 12'(ecd_pkg::Q4_DIV);

    // hour, minute, second
    hp_c    = 23'(s5_sod) * 23'(ecd_pkg::HOUR_RCP);
    hrem_c  = s6_sod - 17'(s6_eh) * 17'(ecd_pkg::HOUR_DIV);
    hge_c   = hrem_c[12:0] >= 13'(ecd_pkg::HOUR_DIV);
    mos_c   = hge_c ? (hrem_c[12:0] - 13'(ecd_pkg::HOUR_DIV)) : hrem_c[12:0];
    mp_c    = 19'(s7_mos) * 19'(ecd_pkg::MIN_RCP);
    mrem_c  = s8_mos - 12'(s8_em) * 12'(ecd_pkg::MIN_DIV);
    mge_c   = mrem_c[6:0] >= 7'(ecd_pkg::MIN_DIV);
    sec_c   = mge_c ? (mrem_c[6:0] - 7'(ecd_pkg::MIN_DIV)) : mrem_c[6:0];

    // year of era
    yp_c    = 28'(s7_num) * 28'(ecd_pkg::YEAR_RCP);
    yrem_c  = s8_num - 18'(s8_ey) * 18'(ecd_pkg::YEAR_DAYS);
    yge_c   = yrem_c[9:0] >= 10'(ecd_pkg::YEAR_DAYS);

    // day of year, March based
    c100_c  = 2'(s9_yoe >= 9'd100) + 2'(s9_yoe >= 9'd200) + 2'(s9_yoe >= 9'd300);
    ystart_c = 18'(s9_yoe) * 18'(ecd_pkg::YEAR_DAYS) + 18'(s9_yoe[8:2]) - 18'(c100_c);
    doy_c   = s9_doe - ystart_c;

    // month index from March
    v11_c   = 11'(s10_doy) * 11'd5 + 11'd2;
    ep_c    = 15'(v11_c) * 15'(ecd_pkg::MP_RCP);
    v12_c   = 11'(s11_doy) * 11'd5 + 11'd2;
    mr_c    = 12'(v12_c) - 12'(s11_emp) * 12'(ecd_pkg::MP_DIV);
    mpge_c  = mr_c[8:0] >= 9'(ecd_pkg::MP_DIV);

    dom_c   = s12_doy - ecd_pkg::month_offset(s12_mp) + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[ecd_pkg::LATENCY-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    s1_ph    <= ph_c;
    s1_pl    <= pl_c;
    s1_x     <= timestamp_ms[42:10];
    s1_low   <= timestamp_ms[9:0];

    s2_q     <= dq_c[49:33];
    s2_x     <= s1_x;
    s2_low   <= s1_low;

    s3_days  <= s2_q + 17'(dge_c);
    s3_x8    <= {rr_c[16:0], s2_low[9:3]};

    s4_se    <= sp_c[40:24];
    s4_x8    <= s3_x8;
    s4_doe   <= doe_c[17:0];
    s4_era5  <= era5_c;

    s5_sod   <= s4_se + 17'(sge_c);
    s5_e1460 <= qp_c[24:18];
    s5_c36   <= 3'(s4_doe >= 18'd36524) + 3'(s4_doe >= 18'd73048)
              + 3'(s4_doe >= 18'd109572) + 3'(s4_doe >= ecd_pkg::ERA_LAST);
    s5_last  <= s4_doe == ecd_pkg::ERA_LAST;
    s5_doe   <= s4_doe;
    s5_era5  <= s4_era5;

    s6_eh    <= hp_c[21:17];
    s6_sod   <= s5_sod;
    s6_q1460 <= s5_e1460 + 7'(qge_c);
    s6_c36   <= s5_c36;
    s6_last  <= s5_last;
    s6_doe   <= s5_doe;
    s6_era5  <= s5_era5;

    s7_hour  <= s6_eh + 5'(hge_c);
    s7_mos   <= mos_c[11:0];
    s7_num   <= s6_doe - 18'(s6_q1460) + 18'(s6_c36) - 18'(s6_last);
    s7_doe   <= s6_doe;
    s7_era5  <= s6_era5;

    s8_em    <= mp_c[17:12];
    s8_mos   <= s7_mos;
    s8_hour  <= s7_hour;
    s8_ey    <= yp_c[26:18];
    s8_num   <= s7_num;
    s8_doe   <= s7_doe;
    s8_era5  <= s7_era5;

    s9_hour  <= s8_hour;
    s9_min   <= s8_em + 6'(mge_c);
    s9_sec   <= sec_c[5:0];
    s9_yoe   <= s8_ey + 9'(yge_c);
    s9_doe   <= s8_doe;
    s9_era5  <= s8_era5;

    s10_hour <= s9_hour;
    s10_min  <= s9_min;
    s10_sec  <= s9_sec;
    s10_yoe  <= s9_yoe;
    s10_doy  <= doy_c[8:0];
    s10_era5 <= s9_era5;

    s11_hour <= s10_hour;
    s11_min  <= s10_min;
    s11_sec  <= s10_sec;
    s11_yoe  <= s10_yoe;
    s11_doy  <= s10_doy;
    s11_emp  <= ep_c[14:11];
    s11_era5 <= s10_era5;

    s12_hour <= s11_hour;
    s12_min  <= s11_min;
    s12_sec  <= s11_sec;
    s12_yoe  <= s11_yoe;
    s12_doy  <= s11_doy;
    s12_mp   <= s11_emp + 4'(mpge_c);
    s12_era5 <= s11_era5;

    // Jan and Feb belong to the next year
    year_since_2000  <= s12_yoe[7:0] + (s12_era5 ? 8'd0 : ecd_pkg::ERA4_YEAR)
                      + 8'(s12_mp >= 4'd10);
    month_number     <= (s12_mp < 4'd10) ? (s12_mp + 4'd3) : (s12_mp - 4'd9);
    day_of_month     <= dom_c[4:0];
    hour_of_day      <= s12_hour;
    minute_of_hour   <= s12_min;
    second_of_minute <= s12_sec;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##(ecd_pkg::LATENCY) done)
    else $error("item did not complete after pipeline latency");

  a_ranges: assert property (@(posedge clk) disable iff (rst)
    done |-> (month_number >= 4'd1 && month_number <= 4'd12 && day_of_month != 5'd0
              && hour_of_day <= 5'd23 && minute_of_hour <= 6'd59
              && second_of_minute <= 6'd59))
    else $error("date or time field out of range");

  a_february: assert property (@(posedge clk) disable iff (rst)
    done |-> (month_number != 4'd2 || day_of_month <= 5'd29))
    else $error("February day beyond 29");

endmodule

// File: bench/epoch_ms_to_calendar_date_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_ms_to_calendar_date_core_tb
// Drives millisecond timestamps into the calendar date core and checks every
// date and time of day against a predictor built on the civil-from-days
// conversion. Corner instants come first: epoch, top of range, unit
// rollovers, leap days and century years. Random items follow, with
// back-to-back bursts and random input gaps.
// ----------------------------------------------------------------------------
module epoch_ms_to_calendar_date_core_tb;

  localparam longint unsigned TS_TOP = 64'd8796093022207;
  localparam longint unsigned MS_DAY = 64'd86400000;
  localparam int unsigned N_RANDOM = 1300;

  typedef struct packed {
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } cal_date_t;

  class date_scoreboard;
    cal_date_t expected_q[$];
    int unsigned items_in;
    int unsigned dates_ok;
    int unsigned errors;

    function cal_date_t calendar_of(logic [42:0] ts);
      longint unsigned days, rem, z, era, doe, yoe, doy, mp, dd, mm, yy;
      cal_date_t r;
      days = ts / MS_DAY;
      rem  = ts % MS_DAY;
      r.hour   = 5'(rem / 3600000);
      rem      = rem % 3600000;
      r.minute = 6'(rem / 60000);
      rem      = rem % 60000;
      r.second = 6'(rem / 1000);
      // day 0 is 1 March of year 0; eras are 400-year cycles
      z   = days + 719468;
      era = z / 146097;
      doe = z - era * 146097;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp  = (5 * doy + 2) / 153;
      dd  = doy - (153 * mp + 2) / 5 + 1;
      mm  = (mp < 10) ? mp + 3 : mp - 9;
      yy  = yoe + era * 400;
      if (mm <= 2) begin
        yy = yy + 1;
      end
      yy = yy - 2000;
      r.year  = yy[7:0];
      r.month = mm[3:0];
      r.day   = dd[4:0];
      return r;
    endfunction

    function void note_timestamp(logic [42:0] ts);
      expected_q.push_back(calendar_of(ts));
      items_in++;
    endfunction

    function void check_date(cal_date_t got);
      cal_date_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: unexpected date y%0d %0d-%0d %0d:%0d:%0d", $realtime,
                   got.year, got.month, got.day, got.hour, got.minute, got.second);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: expected y%0d %0d-%0d %0d:%0d:%0d, got y%0d %0d-%0d %0d:%0d:%0d",
                   $realtime, want.year, want.month, want.day, want.hour, want.minute,
                   want.second, got.year, got.month, got.day, got.hour, got.minute,
                   got.second);
        end
      end else begin
        dates_ok++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [42:0] timestamp_ms = '0;
  logic        busy;
  logic        done;
  logic [7:0]  year_since_2000;
  logic [3:0]  month_number;
  logic [4:0]  day_of_month;
  logic [4:0]  hour_of_day;
  logic [5:0]  minute_of_hour;
  logic [5:0]  second_of_minute;

  date_scoreboard sb = new();
  bit burst = 1'b0;

  epoch_ms_to_calendar_date_core u_top (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .timestamp_ms     (timestamp_ms),
    .busy             (busy),
    .done             (done),
    .year_since_2000  (year_since_2000),
    .month_number     (month_number),
    .day_of_month     (day_of_month),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_date({year_since_2000, month_number, day_of_month, hour_of_day,
                     minute_of_hour, second_of_minute});
    end
  end

  function automatic bit is_leap(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_len(int unsigned y, int unsigned m);
    case (m)
      4, 6, 9, 11: return 30;
      2:           return is_leap(y) ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  // instant of a calendar date, years from 1970 on
  function automatic longint unsigned ms_of_date(int unsigned y, int unsigned m,
                                                 int unsigned d, int unsigned h,
                                                 int unsigned mi, int unsigned s,
                                                 int unsigned ms);
    longint unsigned yy, era, yoe, doy, doe, days;
    yy   = (m <= 2) ? y - 1 : y;
    era  = yy / 400;
    yoe  = yy - era * 400;
    doy  = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
    doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days = era * 146097 + doe - 719468;
    return days * MS_DAY + h * 3600000 + mi * 60000 + s * 1000 + ms;
  endfunction

  function automatic logic [42:0] random_timestamp();
    int unsigned pick, y, mo, d;
    longint unsigned t;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      t = {$urandom, $urandom} & TS_TOP;
    end else if (pick < 7) begin
      y  = $urandom_range(1970, 2247);
      mo = $urandom_range(1, 12);
      d  = ($urandom_range(0, 2) != 0) ? $urandom_range(1, month_len(y, mo))
                                       : month_len(y, mo);
      t  = ms_of_date(y, mo, d, $urandom_range(0, 23), $urandom_range(0, 59),
                      $urandom_range(0, 59), $urandom_range(0, 999));
    end else begin
      // straddle a midnight
      t = longint'($urandom_range(1, 101806)) * MS_DAY - 1000 + $urandom_range(0, 1999);
    end
    if (t > TS_TOP) begin
      t = TS_TOP;
    end
    return t[42:0];
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_ts(input longint unsigned ts, input int unsigned gap);
    start        <= 1'b1;
    timestamp_ms <= ts[42:0];
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    sb.note_timestamp(ts[42:0]);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_ts(0, pick_gap());
    send_ts(TS_TOP, pick_gap());
    send_ts(999, pick_gap());
    send_ts(59999, pick_gap());
    send_ts(3599999, pick_gap());
    send_ts(86399999, pick_gap());
    send_ts(ms_of_date(1970, 12, 31, 23, 59, 59, 999), pick_gap());
    send_ts(ms_of_date(1972, 2, 29, 12, 0, 0, 0), pick_gap());
    send_ts(ms_of_date(1972, 3, 1, 0, 0, 0, 0), pick_gap());
    send_ts(ms_of_date(1999, 12, 31, 23, 59, 59, 999), pick_gap());
    send_ts(ms_of_date(2000, 1, 1, 0, 0, 0, 0), pick_gap());
    send_ts(ms_of_date(2000, 2, 29, 23, 59, 59, 999), pick_gap());
    send_ts(ms_of_date(2000, 3, 1, 0, 0, 0, 0), pick_gap());
    send_ts(ms_of_date(2004, 2, 29, 6, 30, 30, 500), pick_gap());
    send_ts(ms_of_date(2023, 4, 30, 23, 59, 59, 999), pick_gap());
    send_ts(ms_of_date(2024, 2, 29, 0, 0, 0, 0), pick_gap());
    send_ts(ms_of_date(2100, 2, 28, 23, 59, 59, 999), pick_gap());
    send_ts(ms_of_date(2100, 3, 1, 0, 0, 0, 0), pick_gap());
    send_ts(ms_of_date(2200, 2, 28, 23, 59, 59, 999), pick_gap());
    send_ts(ms_of_date(2200, 3, 1, 0, 0, 0, 0), pick_gap());
    send_ts(ms_of_date(2239, 12, 31, 23, 59, 59, 999), pick_gap());
    send_ts(ms_of_date(2240, 1, 1, 0, 0, 0, 0), pick_gap());
    send_ts(ms_of_date(2248, 1, 1, 0, 0, 0, 0), pick_gap());

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 150 == 0) begin
        burst = ($urandom_range(0, 2) == 0);
      end
      send_ts(64'(random_timestamp()), pick_gap());
    end
    start <= 1'b0;

    while (sb.expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (ecd_pkg::LATENCY + 8) @(posedge clk);

    $display("Converted %0d timestamps, %0d dates matched, %0d errors.",
             sb.items_in, sb.dates_ok, sb.errors);
    $display("Range 1970 to 2248: unit rollovers, leap and century days, bursts and gaps.");
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/ecd_pkg.sv
rtl/core/epoch_ms_to_calendar_date_core.sv
bench/epoch_ms_to_calendar_date_core_tb.sv
